// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("check failed");

// Condition in one cycle implies a condition in the next cycle.
`define CHK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ----- rtl/sqvs_pkg.sv -----
package sqvs_pkg;

    localparam int SINE_TABLE_DEPTH_DEF    = 256;
    localparam int PIXEL_FRACTION_BITS_DEF = 4;

    // Quotient bits of every division, set by the 16-bit result fields.
    localparam int DIV_STEPS   = 16;
    localparam int DIV_LATENCY = DIV_STEPS + 1;

    localparam int CFG_W = 14;

    localparam logic [CFG_W-1:0] VIEWPORT_WIDTH_RST  = 14'd1280;
    localparam logic [CFG_W-1:0] VIEWPORT_HEIGHT_RST = 14'd720;
    localparam logic [CFG_W-1:0] TEXTURE_WIDTH_RST   = 14'd1;
    localparam logic [CFG_W-1:0] TEXTURE_HEIGHT_RST  = 14'd1;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    typedef enum logic [1:0] {
        CFG_VIEWPORT_WIDTH,
        CFG_VIEWPORT_HEIGHT,
        CFG_TEXTURE_WIDTH,
        CFG_TEXTURE_HEIGHT
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic signed [15:0] dest_width;
        logic signed [15:0] dest_height;
        logic [15:0]        rotation_angle;
        logic [15:0]        src_x;
        logic [15:0]        src_y;
        logic [15:0]        src_width;
        logic [15:0]        src_height;
        logic [31:0]        color_rgba;
    } req_t;

    typedef struct packed {
        logic [1:0]         corner_index;
        logic signed [15:0] ndc_x;
        logic signed [15:0] ndc_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [31:0]        vertex_color;
        logic               last_corner;
    } vtx_t;

    // Quarter-wave sine in Q14 from a phase x in Q30 quarter turns, by an odd
    // polynomial in Horner form. Only ever called with elaboration constants.
    function automatic logic [14:0] sine_poly(longint x);
        longint x2;
        longint t;
        longint s;
        longint q;
        x2 = (x * x) >>> 30;
        t  = 64'sd172272 - ((x2 * 64'sd3864) >>> 30);
        t  = 64'sd5026995 - ((x2 * t) >>> 30);
        t  = 64'sd85569306 - ((x2 * t) >>> 30);
        t  = 64'sd693598668 - ((x2 * t) >>> 30);
        t  = 64'sd1686629713 - ((x2 * t) >>> 30);
        s  = (x * t) >>> 30;
        q  = (s + 64'sd32768) >>> 16;
        if (q > 64'sd16384)
        begin
            q = 64'sd16384;
        end
        if (q < 64'sd0)
        begin
            q = 64'sd0;
        end
        return q[14:0];
    endfunction

endpackage

// ----- rtl/sqvs_div.sv -----
// Pipelined restoring divider with a 16-bit saturated quotient.
// A negative dividend gives zero, a quotient past 16 bits gives all ones.
module sqvs_div #(
    parameter int NW = 40,
    parameter int DW = 19
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic [15:0]          quo
);

    localparam int RW = DW + sqvs_pkg::DIV_STEPS;
    localparam int NS = sqvs_pkg::DIV_STEPS;

    logic [RW-1:0] rem_reg [NS];
    logic          neg_reg [NS+1];
    logic          hi_reg  [NS+1];
    logic [NS-1:0] q_reg   [1:NS];

    logic neg_in;
    logic hi_in;

    assign neg_in = num[NW-1];
    assign hi_in  = !neg_in && ($unsigned(num) >= NW'({den, {NS{1'b0}}}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= neg_in;
            hi_reg[0]  <= hi_in;
            rem_reg[0] <= num[RW-1:0];
        end
    end

    for (genvar j = 1; j <= NS; j++)
    begin : g_step
        localparam int B = NS - j;
        logic [RW-1:0] dsh;
        logic          ge;
        logic [NS-1:0] q_prev;
        logic [NS-1:0] q_next;

        assign dsh = RW'(den) << B;
        assign ge  = rem_reg[j-1] >= dsh;

        if (j == 1)
        begin : g_first
            assign q_prev = '0;
        end
        else
        begin : g_rest
            assign q_prev = q_reg[j-1];
        end

        always_comb
        begin
            q_next    = q_prev;
            q_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j]   <= q_next;
                neg_reg[j] <= neg_reg[j-1];
                hi_reg[j]  <= hi_reg[j-1];
            end
        end

        if (j < NS)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= ge ? (rem_reg[j-1] - dsh) : rem_reg[j-1];
                end
            end
        end
    end

    assign quo = neg_reg[NS] ? '0 : (hi_reg[NS] ? '1 : q_reg[NS]);

endmodule

// ----- rtl/sprite_quad_vertex_setup_top.sv -----
// Sprite quad vertex setup. A request is taken into a holding register and
// yields four vertices (top-left, top-right, bottom-left, bottom-right),
// one per cycle while the vertex side does not stall, the last one flagged;
// a new request is taken as the last corner leaves the holding register,
// while earlier vertices are still in the pipeline. After the holding
// register, a vertex passes the stages for sine lookup (read straight from
// the request holding register), rotation products and dividend forming,
// the pipelined dividers (a range check and one quotient bit per stage), and
// the output register. A stall on the vertex side freezes the whole pipeline.
// The size registers are meant to change only while no request is in flight.
module sprite_quad_vertex_setup_top #(
    parameter int SINE_TABLE_DEPTH    = sqvs_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int PIXEL_FRACTION_BITS = sqvs_pkg::PIXEL_FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [sqvs_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  sqvs_pkg::req_t                 req_data,
    output logic                           vtx_valid,
    input  logic                           vtx_stall,
    output sqvs_pkg::vtx_t                 vtx_data
);

    localparam int F   = PIXEL_FRACTION_BITS;
    localparam int WDW = sqvs_pkg::CFG_W + F;
    localparam int DW  = WDW + 1;
    localparam int NW  = F + 36;
    localparam int IW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW  = 14 + IW;
    localparam int DL  = sqvs_pkg::DIV_LATENCY;

    // ------------------------------------------------------------------
    // Size registers
    // ------------------------------------------------------------------
    logic [sqvs_pkg::CFG_W-1:0] vp_w_reg;
    logic [sqvs_pkg::CFG_W-1:0] vp_h_reg;
    logic [sqvs_pkg::CFG_W-1:0] tx_w_reg;
    logic [sqvs_pkg::CFG_W-1:0] tx_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_w_reg <= sqvs_pkg::VIEWPORT_WIDTH_RST;
            vp_h_reg <= sqvs_pkg::VIEWPORT_HEIGHT_RST;
            tx_w_reg <= sqvs_pkg::TEXTURE_WIDTH_RST;
            tx_h_reg <= sqvs_pkg::TEXTURE_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (sqvs_pkg::cfg_index_t'(cfg_index))
                sqvs_pkg::CFG_VIEWPORT_WIDTH:  vp_w_reg <= cfg_data;
                sqvs_pkg::CFG_VIEWPORT_HEIGHT: vp_h_reg <= cfg_data;
                sqvs_pkg::CFG_TEXTURE_WIDTH:   tx_w_reg <= cfg_data;
                sqvs_pkg::CFG_TEXTURE_HEIGHT:  tx_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A size of zero is taken as one.
    logic [WDW-1:0] wd;
    logic [WDW-1:0] hd;
    logic [WDW-1:0] twd;
    logic [WDW-1:0] thd;

    assign wd  = WDW'((vp_w_reg == '0) ? 14'd1 : vp_w_reg) << F;
    assign hd  = WDW'((vp_h_reg == '0) ? 14'd1 : vp_h_reg) << F;
    assign twd = WDW'((tx_w_reg == '0) ? 14'd1 : tx_w_reg) << F;
    assign thd = WDW'((tx_h_reg == '0) ? 14'd1 : tx_h_reg) << F;

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless a finished vertex waits.
    // ------------------------------------------------------------------
    logic adv;
    logic vtx_valid_reg;

    assign adv = !(vtx_valid_reg && vtx_stall);

    // ------------------------------------------------------------------
    // Request holding register and corner counter
    // ------------------------------------------------------------------
    sqvs_pkg::req_t hold_reg;
    logic           hold_valid_reg;
    logic [1:0]     cnt_reg;
    logic           req_take;

    assign req_stall = hold_valid_reg && !(adv && (cnt_reg == sqvs_pkg::CORNER_LAST));
    assign req_take  = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= sqvs_pkg::CORNER_FIRST;
        end
        else if (req_take)
        begin
            hold_valid_reg <= 1'b1;
            cnt_reg        <= sqvs_pkg::CORNER_FIRST;
        end
        else if (adv && hold_valid_reg)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == sqvs_pkg::CORNER_LAST)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            hold_reg <= req_data;
        end
    end

    // ------------------------------------------------------------------
    // Quarter-wave sine table and sine / cosine lookup
    // ------------------------------------------------------------------
    logic [14:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_rom
        localparam longint X = (longint'(g) <<< 30) / SINE_TABLE_DEPTH;
        assign sine_rom[g] = sqvs_pkg::sine_poly(X);
    end

    logic signed [15:0] trig [2];

    // Entry 0 is the sine, entry 1 the cosine (a quarter turn ahead).
    for (genvar t = 0; t < 2; t++)
    begin : g_trig
        logic [15:0]   ang;
        logic [PW-1:0] prod;
        logic [IW-1:0] idx;
        logic [IW-1:0] mirror;
        logic [14:0]   mag;

        assign ang    = (t == 0) ? hold_reg.rotation_angle
                                 : hold_reg.rotation_angle + 16'h4000;
        assign prod   = PW'(ang[13:0]) * PW'(SINE_TABLE_DEPTH);
        assign idx    = IW'(prod >> 14);
        assign mirror = IW'(SINE_TABLE_DEPTH) - idx;
        assign mag    = sine_rom[ang[14] ? mirror : idx];
        assign trig[t] = ang[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // ------------------------------------------------------------------
    // Stage A: corner offsets, doubled centre, texture numerators
    // ------------------------------------------------------------------
    logic               a_valid_reg;
    logic [1:0]         a_k_reg;
    logic signed [15:0] a_sin_reg;
    logic signed [15:0] a_cos_reg;
    logic signed [16:0] a_hx_reg;
    logic signed [16:0] a_hy_reg;
    logic signed [17:0] a_bx_reg;
    logic signed [17:0] a_by_reg;
    logic [16:0]        a_un_reg;
    logic [16:0]        a_vn_reg;
    logic [31:0]        a_col_reg;

    logic signed [16:0] dw_ext;
    logic signed [16:0] dh_ext;

    assign dw_ext = 17'(hold_reg.dest_width);
    assign dh_ext = 17'(hold_reg.dest_height);

    // ------------------------------------------------------------------
    // Stage B: rotation products
    // ------------------------------------------------------------------
    logic               b_valid_reg;
    logic [1:0]         b_k_reg;
    logic signed [17:0] b_bx_reg;
    logic signed [17:0] b_by_reg;
    logic [16:0]        b_un_reg;
    logic [16:0]        b_vn_reg;
    logic [31:0]        b_col_reg;
    logic signed [32:0] b_pcx_reg;
    logic signed [32:0] b_psy_reg;
    logic signed [32:0] b_psx_reg;
    logic signed [32:0] b_pcy_reg;

    // ------------------------------------------------------------------
    // Stage C: dividends, each offset so the quotient is non-negative
    // ------------------------------------------------------------------
    logic               c_valid_reg;
    logic [1:0]         c_k_reg;
    logic [31:0]        c_col_reg;
    logic signed [NW-1:0] c_nx_reg;
    logic signed [NW-1:0] c_ny_reg;
    logic signed [NW-1:0] c_nu_reg;
    logic signed [NW-1:0] c_nv_reg;

    logic signed [NW-1:0] x2;
    logic signed [NW-1:0] y2;
    logic signed [NW-1:0] wd_n;
    logic signed [NW-1:0] hd_n;

    assign x2   = (NW'(b_bx_reg) <<< 14) + NW'(b_pcx_reg) - NW'(b_psy_reg);
    assign y2   = (NW'(b_by_reg) <<< 14) + NW'(b_psx_reg) + NW'(b_pcy_reg);
    assign wd_n = NW'(wd);
    assign hd_n = NW'(hd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= hold_valid_reg;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_k_reg   <= cnt_reg;
            a_sin_reg <= trig[0];
            a_cos_reg <= trig[1];
            a_hx_reg  <= cnt_reg[0] ? dw_ext : -dw_ext;
            a_hy_reg  <= cnt_reg[1] ? dh_ext : -dh_ext;
            a_bx_reg  <= (18'(hold_reg.dest_x) <<< 1) + 18'(hold_reg.dest_width);
            a_by_reg  <= (18'(hold_reg.dest_y) <<< 1) + 18'(hold_reg.dest_height);
            a_un_reg  <= cnt_reg[0] ? (17'(hold_reg.src_x) + 17'(hold_reg.src_width))
                                    : 17'(hold_reg.src_x);
            a_vn_reg  <= cnt_reg[1] ? (17'(hold_reg.src_y) + 17'(hold_reg.src_height))
                                    : 17'(hold_reg.src_y);
            a_col_reg <= hold_reg.color_rgba;

            b_k_reg   <= a_k_reg;
            b_bx_reg  <= a_bx_reg;
            b_by_reg  <= a_by_reg;
            b_un_reg  <= a_un_reg;
            b_vn_reg  <= a_vn_reg;
            b_col_reg <= a_col_reg;
            b_pcx_reg <= a_cos_reg * a_hx_reg;
            b_psy_reg <= a_sin_reg * a_hy_reg;
            b_psx_reg <= a_sin_reg * a_hx_reg;
            b_pcy_reg <= a_cos_reg * a_hy_reg;

            // Rounding and the shift into an unsigned quotient range are
            // folded in: ndc_x uses 2*X2 + 32769*W, ndc_y uses 98305*H - 2*Y2.
            c_k_reg   <= b_k_reg;
            c_col_reg <= b_col_reg;
            c_nx_reg  <= (x2 <<< 1) + (wd_n <<< 15) + wd_n;
            c_ny_reg  <= (hd_n <<< 16) + (hd_n <<< 15) + hd_n - (y2 <<< 1);
            c_nu_reg  <= (NW'(b_un_reg) <<< 15) + NW'(twd);
            c_nv_reg  <= (NW'(b_vn_reg) <<< 15) + NW'(thd);
        end
    end

    // ------------------------------------------------------------------
    // Dividers
    // ------------------------------------------------------------------
    logic [15:0] q_x;
    logic [15:0] q_y;
    logic [15:0] q_u;
    logic [15:0] q_v;

    sqvs_div #(.NW(NW), .DW(DW)) u_div_x (
        .clk (clk), .en (adv), .num (c_nx_reg), .den ({wd, 1'b0}), .quo (q_x)
    );
    sqvs_div #(.NW(NW), .DW(DW)) u_div_y (
        .clk (clk), .en (adv), .num (c_ny_reg), .den ({hd, 1'b0}), .quo (q_y)
    );
    sqvs_div #(.NW(NW), .DW(DW)) u_div_u (
        .clk (clk), .en (adv), .num (c_nu_reg), .den ({twd, 1'b0}), .quo (q_u)
    );
    sqvs_div #(.NW(NW), .DW(DW)) u_div_v (
        .clk (clk), .en (adv), .num (c_nv_reg), .den ({thd, 1'b0}), .quo (q_v)
    );

    // Corner, colour and valid travel alongside the divider stages.
    logic        sd_valid_reg [DL];
    logic [1:0]  sd_k_reg     [DL];
    logic [31:0] sd_col_reg   [DL];

    for (genvar i = 0; i < DL; i++)
    begin : g_side
        logic       valid_in;
        logic [1:0] k_in;
        logic [31:0] col_in;

        if (i == 0)
        begin : g_head
            assign valid_in = c_valid_reg;
            assign k_in     = c_k_reg;
            assign col_in   = c_col_reg;
        end
        else
        begin : g_tail
            assign valid_in = sd_valid_reg[i-1];
            assign k_in     = sd_k_reg[i-1];
            assign col_in   = sd_col_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sd_valid_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                sd_valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sd_k_reg[i]   <= k_in;
                sd_col_reg[i] <= col_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    sqvs_pkg::vtx_t vtx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vtx_valid_reg <= sd_valid_reg[DL-1];
        end
    end

    // The device coordinate quotients carry an offset of 32768.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vtx_reg.corner_index <= sd_k_reg[DL-1];
            vtx_reg.ndc_x        <= {~q_x[15], q_x[14:0]};
            vtx_reg.ndc_y        <= {~q_y[15], q_y[14:0]};
            vtx_reg.tex_u        <= q_u;
            vtx_reg.tex_v        <= q_v;
            vtx_reg.vertex_color <= sd_col_reg[DL-1];
            vtx_reg.last_corner  <= (sd_k_reg[DL-1] == sqvs_pkg::CORNER_LAST);
        end
    end

    assign vtx_valid = vtx_valid_reg;
    assign vtx_data  = vtx_reg;

endmodule

// ----- rtl/sqvs_checker.sv -----
`include "assert_macros.svh"

module sqvs_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  logic           vtx_valid,
    input  logic           vtx_stall,
    input  sqvs_pkg::vtx_t vtx_data
);

    logic       req_acc;
    logic       vtx_acc;
    logic [1:0] exp_corner_reg;
    logic [31:0] color_reg;

    assign req_acc = req_valid && !req_stall;
    assign vtx_acc = vtx_valid && !vtx_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_corner_reg <= sqvs_pkg::CORNER_FIRST;
            color_reg      <= '0;
        end
        else if (vtx_acc)
        begin
            exp_corner_reg <= exp_corner_reg + 2'd1;
            color_reg      <= vtx_data.vertex_color;
        end
    end

    `CHK_ASSERT_NEXT(a_vtx_hold, clk, rst_n, vtx_valid && vtx_stall,
        vtx_valid && $stable(vtx_data))

    // Vertices leave in corner order, quad after quad.
    `CHK_ASSERT(a_corner_order, clk, rst_n,
        !vtx_acc || (vtx_data.corner_index == exp_corner_reg))

    `CHK_ASSERT(a_last_flag, clk, rst_n,
        !vtx_valid || (vtx_data.last_corner == (vtx_data.corner_index == sqvs_pkg::CORNER_LAST)))

    // All four vertices of a quad carry the same colour.
    `CHK_ASSERT(a_quad_color, clk, rst_n,
        !(vtx_acc && (exp_corner_reg != sqvs_pkg::CORNER_FIRST))
        || (vtx_data.vertex_color == color_reg))

    // A taken request occupies the front end and stalls the request side.
    `CHK_ASSERT_NEXT(a_req_busy, clk, rst_n, req_acc, req_stall)

endmodule

bind sprite_quad_vertex_setup_top sqvs_checker u_sqvs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx_data  (vtx_data)
);

// ----- sim/tb_sprite_quad_vertex_setup_top.sv -----
`timescale 1ns / 100ps

class quad_scoreboard;
    int             sine_q14[0:256];
    logic [13:0]    vp_w;
    logic [13:0]    vp_h;
    logic [13:0]    tex_w;
    logic [13:0]    tex_h;
    sqvs_pkg::vtx_t pending_vertices[$];
    int             mismatches;
    int             vertices_checked;
    int             requests_seen;

    function new();
        longint x;
        longint x2;
        longint t;
        longint s;
        longint q;
        for (int i = 0; i <= 256; i++)
        begin
            x  = (longint'(i) <<< 30) / 256;
            x2 = (x * x) >>> 30;
            t  = 172272 - ((x2 * 3864) >>> 30);
            t  = 5026995 - ((x2 * t) >>> 30);
            t  = 85569306 - ((x2 * t) >>> 30);
            t  = 693598668 - ((x2 * t) >>> 30);
            t  = 1686629713 - ((x2 * t) >>> 30);
            s  = (x * t) >>> 30;
            q  = (s + 32768) >>> 16;
            if (q > 16384) q = 16384;
            if (q < 0) q = 0;
            sine_q14[i] = int'(q);
        end
        vp_w  = sqvs_pkg::VIEWPORT_WIDTH_RST;
        vp_h  = sqvs_pkg::VIEWPORT_HEIGHT_RST;
        tex_w = sqvs_pkg::TEXTURE_WIDTH_RST;
        tex_h = sqvs_pkg::TEXTURE_HEIGHT_RST;
    endfunction

    function void set_register(sqvs_pkg::cfg_index_t idx, logic [13:0] value);
        case (idx)
            sqvs_pkg::CFG_VIEWPORT_WIDTH:  vp_w  = value;
            sqvs_pkg::CFG_VIEWPORT_HEIGHT: vp_h  = value;
            sqvs_pkg::CFG_TEXTURE_WIDTH:   tex_w = value;
            sqvs_pkg::CFG_TEXTURE_HEIGHT:  tex_h = value;
            default: ;
        endcase
    endfunction

    function longint sine_of(logic [15:0] angle);
        int phase_idx;
        phase_idx = (int'(angle[13:0]) * 256) >> 14;
        case (angle[15:14])
            2'd0: return sine_q14[phase_idx];
            2'd1: return sine_q14[256 - phase_idx];
            2'd2: return -sine_q14[phase_idx];
            default: return -sine_q14[256 - phase_idx];
        endcase
    endfunction

    // Division rounded to nearest, ties toward plus infinity; den is positive.
    function longint round_div(longint num, longint den);
        longint n;
        longint d;
        n = 2 * num + den;
        d = 2 * den;
        if (n >= 0) return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint pixel_scale(logic [13:0] r);
        return longint'(r == 0 ? 14'd1 : r) <<< 4;
    endfunction

    function void note_request(sqvs_pkg::req_t r);
        longint dx, dy, dw, dh, s, c, wd, hd, twd, thd;
        longint u0, u1, v0, v1, hx, hy, x2, y2;
        sqvs_pkg::vtx_t v;
        requests_seen++;
        dx  = longint'($signed(r.dest_x));
        dy  = longint'($signed(r.dest_y));
        dw  = longint'($signed(r.dest_width));
        dh  = longint'($signed(r.dest_height));
        s   = sine_of(r.rotation_angle);
        c   = sine_of(r.rotation_angle + 16'h4000);
        wd  = pixel_scale(vp_w);
        hd  = pixel_scale(vp_h);
        twd = pixel_scale(tex_w);
        thd = pixel_scale(tex_h);
        u0  = clamp(round_div(longint'(r.src_x) * 16384, twd), 0, 65535);
        u1  = clamp(round_div((longint'(r.src_x) + longint'(r.src_width)) * 16384, twd),
                    0, 65535);
        v0  = clamp(round_div(longint'(r.src_y) * 16384, thd), 0, 65535);
        v1  = clamp(round_div((longint'(r.src_y) + longint'(r.src_height)) * 16384, thd),
                    0, 65535);
        for (int k = 0; k < 4; k++)
        begin
            hx = k[0] ? dw : -dw;
            hy = k[1] ? dh : -dh;
            x2 = (2 * dx + dw) * 16384 + c * hx - s * hy;
            y2 = (2 * dy + dh) * 16384 + s * hx + c * hy;
            v.corner_index = k[1:0];
            v.ndc_x        = 16'(clamp(round_div(x2 - 16384 * wd, wd), -32768, 32767));
            v.ndc_y        = 16'(clamp(round_div(16384 * hd - y2, hd), -32768, 32767));
            v.tex_u        = 16'(k[0] ? u1 : u0);
            v.tex_v        = 16'(k[1] ? v1 : v0);
            v.vertex_color = r.color_rgba;
            v.last_corner  = (k == 3);
            pending_vertices.push_back(v);
        end
    endfunction

    function void report(string what, sqvs_pkg::vtx_t e, sqvs_pkg::vtx_t a);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected %p, got %p", $realtime, what, e, a);
        end
    endfunction

    function void check_vertex(sqvs_pkg::vtx_t a);
        sqvs_pkg::vtx_t e;
        if (pending_vertices.size() == 0)
        begin
            report("vertex with no request outstanding", a, a);
            return;
        end
        e = pending_vertices.pop_front();
        vertices_checked++;
        if (a.corner_index !== e.corner_index) report("corner_index", e, a);
        if (a.ndc_x !== e.ndc_x) report("ndc_x", e, a);
        if (a.ndc_y !== e.ndc_y) report("ndc_y", e, a);
        if (a.tex_u !== e.tex_u) report("tex_u", e, a);
        if (a.tex_v !== e.tex_v) report("tex_v", e, a);
        if (a.vertex_color !== e.vertex_color) report("vertex_color", e, a);
        if (a.last_corner !== e.last_corner) report("last_corner", e, a);
    endfunction
endclass

module tb_sprite_quad_vertex_setup_top;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;

    logic           clk;
    logic           rst_n;
    logic           cfg_write;
    logic [1:0]     cfg_index;
    logic [13:0]    cfg_data;
    logic           req_valid;
    logic           req_stall;
    sqvs_pkg::req_t req_data;
    logic           vtx_valid;
    logic           vtx_stall;
    sqvs_pkg::vtx_t vtx_data;

    quad_scoreboard quads;
    bit  quiet;
    bit  hold_request;
    int  cycle_count;
    int  settings_used;

    sprite_quad_vertex_setup_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .vtx_valid (vtx_valid),
        .vtx_stall (vtx_stall),
        .vtx_data  (vtx_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        quads = new();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall) quads.note_request(req_data);
            if (vtx_valid && !vtx_stall) quads.check_vertex(vtx_data);
        end
    end

    // Receiver: random stalls, a quiet window, and one long hold-off on demand.
    initial
    begin
        int hold_left;
        hold_left = 0;
        vtx_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                vtx_stall <= 1'b1;
            end
            else
            begin
                vtx_stall <= !quiet && ($urandom_range(99) < 17);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Leaves req_valid high after acceptance; the caller drives the next item
    // or lowers it, so valid is never dropped and raised in one step.
    task automatic send_request(sqvs_pkg::req_t r);
        int gap;
        if (!quiet && $urandom_range(99) < 17)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (quads.pending_vertices.size() != 0) @(posedge clk);
    endtask

    task automatic write_sizes(logic [13:0] vw, logic [13:0] vh,
                               logic [13:0] tw, logic [13:0] th);
        logic [13:0] vals[4];
        vals = '{vw, vh, tw, th};
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            quads.set_register(sqvs_pkg::cfg_index_t'(i), vals[i]);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    function automatic sqvs_pkg::req_t random_request();
        sqvs_pkg::req_t r;
        logic [191:0]   noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = noise[175:0];
        // Half of the sprites stay on a plausible screen so the outputs do not
        // simply saturate.
        if ($urandom_range(1))
        begin
            r.dest_x      = 16'($signed($urandom_range(2000)) - 500);
            r.dest_y      = 16'($signed($urandom_range(2000)) - 500);
            r.dest_width  = 16'($signed($urandom_range(1200)) - 200);
            r.dest_height = 16'($signed($urandom_range(1200)) - 200);
            r.src_x       = 16'($urandom_range(64));
            r.src_y       = 16'($urandom_range(64));
            r.src_width   = 16'($urandom_range(256));
            r.src_height  = 16'($urandom_range(256));
        end
        return r;
    endfunction

    task automatic random_block(int count);
        for (int n = 0; n < count; n++)
        begin
            send_request(random_request());
        end
    endtask

    initial
    begin
        sqvs_pkg::req_t r;
        logic [15:0] angles[8];
        angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                   16'h2000, 16'h3FFF, 16'h0001};
        settings_used = 0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = sqvs_pkg::CFG_VIEWPORT_WIDTH;
        cfg_data  = '0;
        req_valid = 1'b0;
        req_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset sizes: every corner angle, field
        // extremes and negative sizes that mirror the quad.
        for (int i = 0; i < 8; i++)
        begin
            r = '{dest_x: 16'sd1600, dest_y: 16'sd800, dest_width: 16'sd640,
                  dest_height: 16'sd320, rotation_angle: angles[i], src_x: 16'd16,
                  src_y: 16'd0, src_width: 16'd32, src_height: 16'd48,
                  color_rgba: 32'h11223344};
            send_request(r);
        end
        r = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF};
        send_request(r);
        r = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h6000,
              16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h00000000};
        send_request(r);
        r = '{16'sd100, 16'sd100, -16'sd400, -16'sd300, 16'h1234,
              16'd8, 16'd8, 16'd16, 16'd16, 32'hA5A55A5A};
        send_request(r);
        r = '0;
        send_request(r);

        // Zero registers count as one; full-scale and top-of-range sizes too.
        write_sizes(14'd0, 14'd0, 14'd0, 14'd0);
        random_block(20);
        write_sizes(14'd16383, 14'd16383, 14'd16383, 14'd16383);
        random_block(20);
        write_sizes(14'd8192, 14'd1, 14'd1, 14'd8192);
        random_block(20);
        write_sizes(14'd1920, 14'd1080, 14'd256, 14'd128);
        random_block(60);

        // Long output hold-off while requests keep coming, so the block backs up.
        hold_request = 1'b1;
        random_block(40);
        wait_drained();

        quiet = 1'b1;
        random_block(60);
        quiet = 1'b0;

        write_sizes(14'($urandom_range(16383)), 14'($urandom_range(16383)),
                    14'($urandom_range(64)), 14'($urandom_range(64)));
        random_block(60);
        write_sizes(14'd640, 14'd480, 14'd32, 14'd32);
        random_block(70);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (quads.pending_vertices.size() != 0)
        begin
            quads.mismatches++;
            void'(quads.pending_vertices.pop_front());
        end
        $display("Run covered %0d sprite requests and %0d vertices over %0d size settings,",
                 quads.requests_seen, quads.vertices_checked, settings_used + 1);
        $display("with random stalls, a long output hold-off and a full drain pause.");
        if (quads.mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sqvs_pkg.sv
rtl/sqvs_div.sv
rtl/sprite_quad_vertex_setup_top.sv
rtl/sqvs_checker.sv
sim/tb_sprite_quad_vertex_setup_top.sv
